// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked property helpers for the rtl file that carries checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lsag_pkg.sv =====
// ----------------------------------------------------------------------------
// lsag_pkg
// shared types, constants and gf(2) helpers of the lfsr address generator
// ----------------------------------------------------------------------------
`default_nettype none

package lsag_pkg;

    localparam int NUM_STREAMS = 16;
    localparam int STREAM_W    = $clog2(NUM_STREAMS);
    localparam int LINE_BITS   = 40;
    localparam int CFG_W       = 6;
    localparam logic [CFG_W-1:0] INDEX_BITS_RST = 6'd25;

    localparam logic [63:0] TAPS = 64'h0000_0000_0000_0007;
    localparam logic [63:0] LFSR_ONE = 64'h0000_0000_0000_0001;
    localparam logic signed [63:0] PERIOD = 64'sd1317624576693539401;
    localparam logic signed [63:0] NEG_PERIOD = -PERIOD;

    // bits 62 down to 0 of the folded position are walked, one per cycle
    localparam int JUMP_STEPS = 63;
    localparam int JCNT_W     = $clog2(JUMP_STEPS);

    localparam logic ACT_SEED = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef struct packed {
        logic                action;
        logic [3:0]          stream;
        logic signed [63:0]  position;
    } t_in_item;

    typedef struct packed {
        logic [63:0]           value;
        logic [LINE_BITS-1:0]  line_index;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FOLD = 4'b0010,
        S_JUMP = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // multiply by x modulo x^64 + x^2 + x + 1
    function automatic logic [63:0] mul_x(input logic [63:0] v);
        return {v[62:0], 1'b0} ^ (v[63] ? TAPS : 64'h0);
    endfunction

    // v^2 modulo the polynomial: low half spreads to even bits, high half
    // spreads the same way and is folded back through x^64 = x^2 + x + 1
    function automatic logic [63:0] gf_square(input logic [63:0] v);
        logic [63:0] lo;
        logic [63:0] hi;
        lo = '0;
        hi = '0;
        for (int j = 0; j < 32; j++) begin
            lo[2*j] = v[j];
            hi[2*j] = v[32+j];
        end
        return lo ^ hi ^ {hi[62:0], 1'b0} ^ {hi[61:0], 2'b00}
               ^ (hi[62] ? TAPS : 64'h0);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lsag_fold.sv =====
// ----------------------------------------------------------------------------
// lsag_fold
// folds a signed position into [0, period] by repeated add or subtract
// ----------------------------------------------------------------------------
`default_nettype none

module lsag_fold (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic signed [63:0]              i_raw,
    output logic                                 o_done,
    output logic [lsag_pkg::JUMP_STEPS-1:0]      o_n
);

    logic               r_busy;
    logic signed [63:0] r_val;
    logic signed [63:0] n_val;
    logic               in_range;

    // one shared add/compare per cycle
    assign in_range = !r_val[63] && (r_val <= lsag_pkg::PERIOD);
    assign n_val    = r_val + (r_val[63] ? lsag_pkg::PERIOD : lsag_pkg::NEG_PERIOD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && in_range) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_raw;
        end else if (r_busy && !in_range) begin
            r_val <= n_val;
        end
    end

    assign o_done = r_busy && in_range;
    assign o_n    = r_val[lsag_pkg::JUMP_STEPS-1:0];

endmodule

`default_nettype wire

// ===== rtl/lsag_jump.sv =====
// ----------------------------------------------------------------------------
// lsag_jump
// square-and-multiply-by-x walk that computes x^n modulo the polynomial
// ----------------------------------------------------------------------------
`default_nettype none

module lsag_jump (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [lsag_pkg::JUMP_STEPS-1:0] i_n,
    output logic                                 o_done,
    output logic [63:0]                          o_value
);

    localparam logic [lsag_pkg::JCNT_W-1:0] CNT_LAST =
        lsag_pkg::JCNT_W'(lsag_pkg::JUMP_STEPS - 1);

    logic                            r_busy;
    logic                            r_done;
    logic [lsag_pkg::JCNT_W-1:0]     r_cnt;
    logic [lsag_pkg::JUMP_STEPS-1:0] r_n;
    logic [63:0]                     r_acc;
    logic [63:0]                     sq;
    logic [63:0]                     n_acc;

    // leading zero bits keep the accumulator at one, so no top-bit search
    assign sq    = lsag_pkg::gf_square(r_acc);
    assign n_acc = r_n[lsag_pkg::JUMP_STEPS-1] ? lsag_pkg::mul_x(sq) : sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_LAST;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_acc <= lsag_pkg::LFSR_ONE;
        end else if (r_busy) begin
            r_n   <= {r_n[lsag_pkg::JUMP_STEPS-2:0], 1'b0};
            r_acc <= n_acc;
        end
    end

    assign o_done  = r_done;
    assign o_value = r_acc;

endmodule

`default_nettype wire

// ===== rtl/lfsr_stream_address_generator_unit.sv =====
// ----------------------------------------------------------------------------
// lfsr_stream_address_generator_unit
// sixteen 64-bit galois lfsr streams with seed-by-position and single step
// ----------------------------------------------------------------------------
// A step transaction shifts the addressed stream once and the result is in the
// output register in the cycle after acceptance. A seed transaction runs first
// through the fold unit (one 64-bit add and compare per cycle, eight adds at
// most for the most negative position), then through the jump unit, which does
// one gf(2) squaring and optional multiply by x per cycle over bits 62 to 0 of
// the folded position, then the jump done flag is registered, and the done
// state writes the stream and loads the output. A stalled output register
// holds the write back for as long as the stall lasts. One transaction is in
// flight at a time; a new one is taken only while the block is idle and the
// output register is empty or being read in that same cycle.
// All streams hold 1 right after reset, with no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module lfsr_stream_address_generator_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire lsag_pkg::t_in_item             i_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output lsag_pkg::t_out_item                 o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [lsag_pkg::CFG_W-1:0]     i_cfg_wdata
);

    lsag_pkg::t_state                  r_state;
    lsag_pkg::t_state                  n_state;
    logic [lsag_pkg::STREAM_W-1:0]     r_slot;
    logic [lsag_pkg::CFG_W-1:0]        r_index_bits;
    logic [63:0]                       r_streams [lsag_pkg::NUM_STREAMS];
    logic                              r_out_valid;
    lsag_pkg::t_out_item               r_out;

    logic                              in_accept;
    logic                              out_free;
    logic [lsag_pkg::STREAM_W-1:0]     in_slot;
    logic                              fold_start;
    logic                              fold_done;
    logic [lsag_pkg::JUMP_STEPS-1:0]   fold_n;
    logic                              jump_done;
    logic [63:0]                       jump_value;
    logic                              wr_en;
    logic [lsag_pkg::STREAM_W-1:0]     wr_slot;
    logic [63:0]                       wr_data;
    logic [lsag_pkg::LINE_BITS-1:0]    line_mask;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != lsag_pkg::S_IDLE) || !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_slot    = i_in.stream[lsag_pkg::STREAM_W-1:0];
    assign fold_start = in_accept && (i_in.action == lsag_pkg::ACT_SEED);

    lsag_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (fold_start),
        .i_raw   (i_in.position),
        .o_done  (fold_done),
        .o_n     (fold_n)
    );

    lsag_jump u_jump (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (fold_done),
        .i_n     (fold_n),
        .o_done  (jump_done),
        .o_value (jump_value)
    );

    always_comb begin
        n_state = r_state;
        wr_en   = 1'b0;
        wr_slot = r_slot;
        wr_data = jump_value;
        case (r_state)
            lsag_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (i_in.action == lsag_pkg::ACT_SEED) begin
                        n_state = lsag_pkg::S_FOLD;
                    end else begin
                        wr_en   = 1'b1;
                        wr_slot = in_slot;
                        wr_data = lsag_pkg::mul_x(r_streams[in_slot]);
                    end
                end
            end
            lsag_pkg::S_FOLD: begin
                if (fold_done) begin
                    n_state = lsag_pkg::S_JUMP;
                end
            end
            lsag_pkg::S_JUMP: begin
                if (jump_done) begin
                    n_state = lsag_pkg::S_DONE;
                end
            end
            lsag_pkg::S_DONE: begin
                if (out_free) begin
                    wr_en   = 1'b1;
                    n_state = lsag_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lsag_pkg::S_IDLE;
            end
        endcase
    end

    // mask saturates at the line index width
    always_comb begin
        for (int k = 0; k < lsag_pkg::LINE_BITS; k++) begin
            line_mask[k] = (r_index_bits > lsag_pkg::CFG_W'(k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lsag_pkg::S_IDLE;
            r_index_bits <= lsag_pkg::INDEX_BITS_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_index_bits <= i_cfg_wdata;
            end
            if (wr_en) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < lsag_pkg::NUM_STREAMS; s++) begin
                r_streams[s] <= lsag_pkg::LFSR_ONE;
            end
        end else if (wr_en) begin
            r_streams[wr_slot] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_slot <= in_slot;
        end
        if (wr_en) begin
            r_out.value      <= wr_data;
            r_out.line_index <= wr_data[lsag_pkg::LINE_BITS-1:0] & line_mask;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `ASSERT_NEXT(a_step_loads_out,
        in_accept && (i_in.action == lsag_pkg::ACT_STEP), r_out_valid,
        "step transaction did not load the output register")
    `ASSERT_NEXT(a_seed_enters_fold,
        fold_start, r_state == lsag_pkg::S_FOLD,
        "seed transaction did not start the fold")
    `ASSERT_SAME(a_jump_done_in_jump,
        jump_done, r_state == lsag_pkg::S_JUMP,
        "jump unit finished outside the jump state")
    `ASSERT_SAME(a_value_nonzero,
        r_out_valid, r_out.value != 64'h0,
        "lfsr value reached zero")

endmodule

`default_nettype wire
